[hdl/gcd_pkg.sv]
// shared widths, constants and the cordic arctangent table of the great-circle unit
`timescale 1ns / 1ps

package gcd_pkg;

	// angle input to a sine/cosine unit, units of 2^-23 degree
	localparam int unsigned AW = 33;
	// cordic datapath width
	localparam int unsigned CW = 34;
	// sine and cosine result width, q30
	localparam int unsigned SCW = 32;
	// square root datapath and result widths
	localparam int unsigned RW = 62;
	localparam int unsigned SQ_BITS = 31;
	// floor(v / 45) as (v * RECIP_45) >> 43, exact for v below 2^37
	localparam logic [37:0] RECIP_45 = 38'd195468733827;
	// registered stages between the angle input and the first cordic cell
	localparam int unsigned SC_PRE = 7;

	localparam logic signed [33:0] FULL_TURN = 34'sd3019898880;
	localparam logic signed [33:0] DEG180_W = 34'sd1509949440;
	localparam logic signed [31:0] DEG180 = 32'sd1509949440;
	localparam logic signed [31:0] DEG90 = 32'sd754974720;
	localparam logic [61:0] DEG180_HALF = 62'd754974720;
	localparam logic [31:0] PI_Q30 = 32'd3373259426;
	localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [61:0] ONE_Q60 = 62'd1 << 60;
	localparam logic [23:0] RADIUS_RESET = 24'd6371000;

	localparam logic [30:0] ATAN_HEAD [10] = '{
		31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
		31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149
	};

	// q30 arctangent of 2^-i
	function automatic logic signed [CW-1:0] atan_step(input int unsigned i);
		logic signed [CW-1:0] r;
		if (i < 10) begin
			r = CW'(ATAN_HEAD[i[3:0]]);
		end else if (i <= 30) begin
			r = CW'(1) << (30 - i);
		end else begin
			r = '0;
		end
		return r;
	endfunction

endpackage

[hdl/gcd_rot_cell.sv]
// one cordic rotation step with its output register
`timescale 1ns / 1ps

module gcd_rot_cell #(
	parameter int unsigned STEP = 0
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [gcd_pkg::CW-1:0]     x,
	input  logic signed [gcd_pkg::CW-1:0]     y,
	input  logic signed [gcd_pkg::CW-1:0]     z,
	output logic signed [gcd_pkg::CW-1:0]     x_q,
	output logic signed [gcd_pkg::CW-1:0]     y_q,
	output logic signed [gcd_pkg::CW-1:0]     z_q
);

	logic signed [gcd_pkg::CW-1:0] dx;
	logic signed [gcd_pkg::CW-1:0] dy;
	logic signed [gcd_pkg::CW-1:0] da;

	assign dx = y >>> STEP;
	assign dy = x >>> STEP;
	assign da = gcd_pkg::atan_step(STEP);

	always_ff @(posedge clk) begin
		if (en) begin
			if (z >= 0) begin
				x_q <= x - dx;
				y_q <= y + dy;
				z_q <= z - da;
			end else begin
				x_q <= x + dx;
				y_q <= y - dy;
				z_q <= z + da;
			end
		end
	end

endmodule

[hdl/gcd_sincos.sv]
// angle reduction, degree to radian scaling and cordic sine/cosine pipeline
`timescale 1ns / 1ps

module gcd_sincos #(
	parameter int unsigned CORDIC_STAGES = 32
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [gcd_pkg::AW-1:0]     angle,
	output logic signed [gcd_pkg::SCW-1:0]    sine,
	output logic signed [gcd_pkg::SCW-1:0]    cosine
);

	localparam int unsigned ZST = gcd_pkg::SC_PRE;

	logic signed [33:0]            ang_w;
	logic signed [31:0]            red_s1;
	logic [29:0]                   mag_s2;
	logic [61:0]                   prod_s3;
	logic [61:0]                   rsum;
	logic [36:0]                   quo_n_s4;
	logic [37:0]                   pp_hh_s5;
	logic [37:0]                   pp_hl_s5;
	logic [37:0]                   pp_lh_s5;
	logic [37:0]                   pp_ll_s5;
	logic [75:0]                   qsum;
	logic [30:0]                   rad_s6;
	logic                          neg_q [2:ZST-1];
	logic                          flip_q [2:CORDIC_STAGES+ZST];
	logic signed [gcd_pkg::CW-1:0] rad_w;
	logic signed [gcd_pkg::CW-1:0] cx [CORDIC_STAGES+1];
	logic signed [gcd_pkg::CW-1:0] cy [CORDIC_STAGES+1];
	logic signed [gcd_pkg::CW-1:0] cz [CORDIC_STAGES+1];
	logic                          fold_flip;
	logic                          fold_neg;
	logic [29:0]                   fold_mag;

	assign ang_w = 34'(angle);

	// a single turn added or taken away covers the whole input range
	always_ff @(posedge clk) begin
		if (en) begin
			if (ang_w >= gcd_pkg::DEG180_W) begin
				red_s1 <= 32'(ang_w - gcd_pkg::FULL_TURN);
			end else if (ang_w < -gcd_pkg::DEG180_W) begin
				red_s1 <= 32'(ang_w + gcd_pkg::FULL_TURN);
			end else begin
				red_s1 <= 32'(ang_w);
			end
		end
	end

	// fold into [-90, 90] degrees, cosine sign kept aside
	always_comb begin
		fold_flip = 1'b0;
		fold_neg = 1'b0;
		if (red_s1 > gcd_pkg::DEG90) begin
			fold_mag = 30'(gcd_pkg::DEG180 - red_s1);
			fold_flip = 1'b1;
		end else if (red_s1 < -gcd_pkg::DEG90) begin
			fold_mag = 30'(red_s1 + gcd_pkg::DEG180);
			fold_flip = 1'b1;
			fold_neg = 1'b1;
		end else if (red_s1 < 0) begin
			fold_mag = 30'(-red_s1);
			fold_neg = 1'b1;
		end else begin
			fold_mag = 30'(red_s1);
		end
	end

	assign rsum = prod_s3 + gcd_pkg::DEG180_HALF;

	// divide by 45 after the shift by 2^25: reciprocal product in four partial products
	assign qsum = (76'(pp_hh_s5) << 38) + (76'(pp_hl_s5) << 19) + (76'(pp_lh_s5) << 19)
		+ 76'(pp_ll_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2 <= fold_mag;
			neg_q[2] <= fold_neg;
			flip_q[2] <= fold_flip;
			prod_s3 <= 62'(mag_s2) * 62'(gcd_pkg::PI_Q30);
			quo_n_s4 <= rsum[61:25];
			pp_hh_s5 <= 38'(quo_n_s4[36:19]) * 38'(gcd_pkg::RECIP_45[37:19]);
			pp_hl_s5 <= 38'(quo_n_s4[36:19]) * 38'(gcd_pkg::RECIP_45[18:0]);
			pp_lh_s5 <= 38'(quo_n_s4[18:0]) * 38'(gcd_pkg::RECIP_45[37:19]);
			pp_ll_s5 <= 38'(quo_n_s4[18:0]) * 38'(gcd_pkg::RECIP_45[18:0]);
			rad_s6 <= qsum[73:43];
			for (int j = 3; j < ZST; j++) begin
				neg_q[j] <= neg_q[j-1];
			end
			for (int j = 3; j <= CORDIC_STAGES + ZST; j++) begin
				flip_q[j] <= flip_q[j-1];
			end
		end
	end

	assign rad_w = gcd_pkg::CW'(rad_s6);

	always_ff @(posedge clk) begin
		if (en) begin
			cz[0] <= neg_q[ZST-1] ? -rad_w : rad_w;
		end
	end

	assign cx[0] = gcd_pkg::GAIN_Q30;
	assign cy[0] = '0;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		gcd_rot_cell #(
			.STEP(i)
		) u_cell (
			.clk(clk),
			.en (en),
			.x  (cx[i]),
			.y  (cy[i]),
			.z  (cz[i]),
			.x_q(cx[i+1]),
			.y_q(cy[i+1]),
			.z_q(cz[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sine <= gcd_pkg::SCW'(cy[CORDIC_STAGES]);
			cosine <= flip_q[CORDIC_STAGES+ZST] ? gcd_pkg::SCW'(-cx[CORDIC_STAGES])
				: gcd_pkg::SCW'(cx[CORDIC_STAGES]);
		end
	end

endmodule

[hdl/gcd_sqrt_cell.sv]
// one bit of a digit-by-digit integer square root
`timescale 1ns / 1ps

module gcd_sqrt_cell #(
	parameter int unsigned K = 0
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [gcd_pkg::RW-1:0]        rem,
	input  logic [gcd_pkg::SQ_BITS-1:0]   root,
	output logic [gcd_pkg::RW-1:0]        rem_q,
	output logic [gcd_pkg::SQ_BITS-1:0]   root_q
);

	logic [gcd_pkg::RW-1:0] trial;

	// (root + 2^k)^2 - root^2, root has no bits at or below k yet
	assign trial = (gcd_pkg::RW'(root) << (K + 1)) | (gcd_pkg::RW'(1) << (2 * K));

	always_ff @(posedge clk) begin
		if (en) begin
			if (rem >= trial) begin
				rem_q <= rem - trial;
				root_q <= root | (gcd_pkg::SQ_BITS'(1) << K);
			end else begin
				rem_q <= rem;
				root_q <= root;
			end
		end
	end

endmodule

[hdl/gcd_vec_cell.sv]
// one cordic vectoring step with its output register
`timescale 1ns / 1ps

module gcd_vec_cell #(
	parameter int unsigned STEP = 0
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [gcd_pkg::CW-1:0]     x,
	input  logic signed [gcd_pkg::CW-1:0]     y,
	input  logic signed [gcd_pkg::CW-1:0]     z,
	output logic signed [gcd_pkg::CW-1:0]     x_q,
	output logic signed [gcd_pkg::CW-1:0]     y_q,
	output logic signed [gcd_pkg::CW-1:0]     z_q
);

	logic signed [gcd_pkg::CW-1:0] dx;
	logic signed [gcd_pkg::CW-1:0] dy;
	logic signed [gcd_pkg::CW-1:0] da;

	assign dx = y >>> STEP;
	assign dy = x >>> STEP;
	assign da = gcd_pkg::atan_step(STEP);

	always_ff @(posedge clk) begin
		if (en) begin
			if (y >= 0) begin
				x_q <= x + dx;
				y_q <= y - dy;
				z_q <= z + da;
			end else begin
				x_q <= x - dx;
				y_q <= y + dy;
				z_q <= z - da;
			end
		end
	end

endmodule

[hdl/great_circle_distance_unit.sv]
// top level of the haversine great-circle distance pipeline
// usage:
//   in channel (in_valid / in_stall) carries two points, longitude and latitude
//   in signed degrees * 2^22. out channel (out_valid / out_stall) returns the
//   central angle in radians * 2^29 and the surface distance in meters * 2^8.
//   cfg_wr_en / cfg_wr_data load the sphere radius in whole meters; write it
//   only while no transfer is in flight.
// the pipeline depth is set by the two cordic chains, sine/cosine and angle, plus
// the 31-cell square root chain that lies between them.
// one transfer is taken every cycle while the output is not stalled.
// a stalled result freezes the whole pipeline, in_stall follows out_stall
// only while a result is waiting; bubbles in the pipeline never hold it.
// reset empties the pipeline and loads a radius of 6371000 m.
`timescale 1ns / 1ps

module great_circle_distance_unit #(
	parameter int unsigned CORDIC_STAGES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] lon_a,
	input  logic signed [29:0] lat_a,
	input  logic signed [31:0] lon_b,
	input  logic signed [29:0] lat_b,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [30:0]        central_angle,
	output logic [33:0]        distance,
	input  logic               cfg_wr_en,
	input  logic [23:0]        cfg_wr_data
);

	// sine/cosine unit depth, counted from its registered input
	localparam int unsigned SC_LAT = CORDIC_STAGES + gcd_pkg::SC_PRE + 1;
	localparam int unsigned LAT = SC_LAT + 7 + gcd_pkg::SQ_BITS + CORDIC_STAGES + 4;

	logic                           en;
	logic                           vld_q [LAT];
	logic [23:0]                    sphere_radius_q;

	logic signed [gcd_pkg::AW-1:0]  dlat_s0;
	logic signed [gcd_pkg::AW-1:0]  dlon_s0;
	logic signed [gcd_pkg::AW-1:0]  la2_s0;
	logic signed [gcd_pkg::AW-1:0]  lb2_s0;

	logic signed [gcd_pkg::SCW-1:0] sin_lat;
	logic signed [gcd_pkg::SCW-1:0] sin_lon;
	logic signed [gcd_pkg::SCW-1:0] cos_a;
	logic signed [gcd_pkg::SCW-1:0] cos_b;

	logic signed [63:0]             sq_s1, sq_s2, sq_s3, sq_s4, sq_s5;
	logic signed [63:0]             cc_s1;
	logic signed [gcd_pkg::SCW-1:0] s2_s1, s2_s2, s2_s3, s2_s4;
	logic signed [33:0]             ccq_s2;
	logic signed [65:0]             t_s3;
	logic signed [33:0]             tq_s4;
	logic signed [65:0]             u_s5;
	logic signed [66:0]             asum;
	logic [60:0]                    a_s6;
	logic [gcd_pkg::RW-1:0]         va_s7, vb_s7;

	logic [gcd_pkg::RW-1:0]         srem_a [gcd_pkg::SQ_BITS+1];
	logic [gcd_pkg::SQ_BITS-1:0]    sroot_a [gcd_pkg::SQ_BITS+1];
	logic [gcd_pkg::RW-1:0]         srem_b [gcd_pkg::SQ_BITS+1];
	logic [gcd_pkg::SQ_BITS-1:0]    sroot_b [gcd_pkg::SQ_BITS+1];

	logic signed [gcd_pkg::CW-1:0]  vx [CORDIC_STAGES+1];
	logic signed [gcd_pkg::CW-1:0]  vy [CORDIC_STAGES+1];
	logic signed [gcd_pkg::CW-1:0]  vz [CORDIC_STAGES+1];
	logic                           yz_q [CORDIC_STAGES];
	logic                           xz_q [CORDIC_STAGES];

	logic [30:0]                    ang_q;
	logic [30:0]                    ang_m_q;
	logic [54:0]                    dprod_q;
	logic [55:0]                    dsum;
	logic signed [gcd_pkg::CW-1:0]  zf;

	assign out_valid = vld_q[LAT-1];
	assign en = !(vld_q[LAT-1] && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < LAT; j++) begin
				vld_q[j] <= 1'b0;
			end
			sphere_radius_q <= gcd_pkg::RADIUS_RESET;
		end else begin
			if (en) begin
				vld_q[0] <= in_valid;
				for (int j = 1; j < LAT; j++) begin
					vld_q[j] <= vld_q[j-1];
				end
			end
			if (cfg_wr_en) begin
				sphere_radius_q <= cfg_wr_data;
			end
		end
	end

	// half angles use raw differences, cosines use doubled latitudes
	always_ff @(posedge clk) begin
		if (en) begin
			dlat_s0 <= gcd_pkg::AW'(lat_b) - gcd_pkg::AW'(lat_a);
			dlon_s0 <= gcd_pkg::AW'(lon_b) - gcd_pkg::AW'(lon_a);
			la2_s0 <= gcd_pkg::AW'(lat_a) <<< 1;
			lb2_s0 <= gcd_pkg::AW'(lat_b) <<< 1;
		end
	end

	gcd_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_dlat (
		.clk(clk), .en(en), .angle(dlat_s0), .sine(sin_lat), .cosine()
	);
	gcd_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_dlon (
		.clk(clk), .en(en), .angle(dlon_s0), .sine(sin_lon), .cosine()
	);
	gcd_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_lata (
		.clk(clk), .en(en), .angle(la2_s0), .sine(), .cosine(cos_a)
	);
	gcd_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_latb (
		.clk(clk), .en(en), .angle(lb2_s0), .sine(), .cosine(cos_b)
	);

	assign asum = 67'(sq_s5) + 67'(u_s5);

	// haversine term in q60, rounded q30 products in between
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1 <= 64'(sin_lat) * 64'(sin_lat);
			cc_s1 <= 64'(cos_a) * 64'(cos_b);
			s2_s1 <= sin_lon;
			ccq_s2 <= 34'((cc_s1 + 64'sd536870912) >>> 30);
			s2_s2 <= s2_s1;
			sq_s2 <= sq_s1;
			t_s3 <= 66'(ccq_s2) * 66'(s2_s2);
			s2_s3 <= s2_s2;
			sq_s3 <= sq_s2;
			tq_s4 <= 34'((t_s3 + 66'sd536870912) >>> 30);
			s2_s4 <= s2_s3;
			sq_s4 <= sq_s3;
			u_s5 <= 66'(tq_s4) * 66'(s2_s4);
			sq_s5 <= sq_s4;
			if (asum < 0) begin
				a_s6 <= '0;
			end else if (asum > 67'(gcd_pkg::ONE_Q60)) begin
				a_s6 <= 61'(gcd_pkg::ONE_Q60);
			end else begin
				a_s6 <= 61'(asum);
			end
			va_s7 <= gcd_pkg::RW'(a_s6);
			vb_s7 <= gcd_pkg::ONE_Q60 - gcd_pkg::RW'(a_s6);
		end
	end

	assign srem_a[0] = va_s7;
	assign sroot_a[0] = '0;
	assign srem_b[0] = vb_s7;
	assign sroot_b[0] = '0;

	for (genvar j = 0; j < gcd_pkg::SQ_BITS; j++) begin : g_sqrt
		gcd_sqrt_cell #(.K(gcd_pkg::SQ_BITS - 1 - j)) u_sqa (
			.clk(clk), .en(en),
			.rem(srem_a[j]), .root(sroot_a[j]),
			.rem_q(srem_a[j+1]), .root_q(sroot_a[j+1])
		);
		gcd_sqrt_cell #(.K(gcd_pkg::SQ_BITS - 1 - j)) u_sqb (
			.clk(clk), .en(en),
			.rem(srem_b[j]), .root(sroot_b[j]),
			.rem_q(srem_b[j+1]), .root_q(sroot_b[j+1])
		);
	end

	// atan2(sqrt(a), sqrt(1-a)), zero inputs handled beside the chain
	assign vx[0] = gcd_pkg::CW'(sroot_b[gcd_pkg::SQ_BITS]);
	assign vy[0] = gcd_pkg::CW'(sroot_a[gcd_pkg::SQ_BITS]);
	assign vz[0] = '0;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
		gcd_vec_cell #(.STEP(i)) u_cell (
			.clk(clk), .en(en),
			.x(vx[i]), .y(vy[i]), .z(vz[i]),
			.x_q(vx[i+1]), .y_q(vy[i+1]), .z_q(vz[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yz_q[0] <= (sroot_a[gcd_pkg::SQ_BITS] == '0);
			xz_q[0] <= (sroot_b[gcd_pkg::SQ_BITS] == '0);
			for (int j = 1; j < CORDIC_STAGES; j++) begin
				yz_q[j] <= yz_q[j-1];
				xz_q[j] <= xz_q[j-1];
			end
		end
	end

	assign zf = vz[CORDIC_STAGES];
	assign dsum = 56'(dprod_q) + (56'd1 << 20);

	always_ff @(posedge clk) begin
		if (en) begin
			if (yz_q[CORDIC_STAGES-1]) begin
				ang_q <= '0;
			end else if (xz_q[CORDIC_STAGES-1]) begin
				ang_q <= gcd_pkg::HALF_PI_Q30;
			end else if (zf < 0) begin
				ang_q <= '0;
			end else if (zf > gcd_pkg::CW'(gcd_pkg::HALF_PI_Q30)) begin
				ang_q <= gcd_pkg::HALF_PI_Q30;
			end else begin
				ang_q <= zf[30:0];
			end
			dprod_q <= 55'(ang_q) * 55'(sphere_radius_q);
			ang_m_q <= ang_q;
			central_angle <= ang_m_q;
			distance <= dsum[54:21];
		end
	end

endmodule
